@@ sv/ntip_pkg.sv @@
// Shared types and constants for the node-to-IP learning table.
package ntip_pkg;

  localparam int NODE_W          = 48;
  localparam int IP_W            = 32;
  localparam int STATUS_W        = 3;
  localparam int ENTRY_W         = NODE_W + IP_W;
  localparam int TABLE_DEPTH_DEF = 32;

  // Operation codes carried by an input item.
  localparam logic OP_LEARN  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input item and restart the scan
    logic search;   // step the table scan
    logic resolve;  // finish the item: write the table for a learn that hits or finds room, and form the result
    logic push;     // move the result into the output register
  } ntip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;       // the entry read out last cycle holds the key
    logic done;      // every stored entry was compared without a match
    logic out_free;  // the output register can take a result this cycle
  } ntip_stat_t;

endpackage

@@ sv/ntip_ctrl.sv @@
// Controller state machine for the node-to-IP learning table.
module ntip_ctrl import ntip_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ntip_stat_t st,
  output ntip_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_PUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (st.hit || st.done) begin
          cmd.resolve = 1'b1;
          state_nxt   = S_PUSH;
        end
      end
      S_PUSH: begin
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/ntip_dp.sv @@
// Datapath of the node-to-IP learning table: entry memory, scan and result registers.
module ntip_dp import ntip_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_op,
  input  logic [NODE_W-1:0]   in_node_address,
  input  logic [IP_W-1:0]     in_ip_address,
  input  ntip_cmd_t           cmd,
  output ntip_stat_t          st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [IP_W-1:0]     out_found_ip
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  logic                key_op_r;
  logic [NODE_W-1:0]   key_node_r;
  logic [IP_W-1:0]     key_ip_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       addr_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_idx_r;
  logic [NODE_W-1:0]   rd_node_r;
  logic [IP_W-1:0]     rd_ip_r;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IP_W-1:0]     res_ip_r, res_ip_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IP_W-1:0]     out_ip_r;

  logic                hit_now;
  logic                issue;
  logic                full;
  logic                wr_en;
  logic [AW-1:0]       wr_idx;
  logic [ENTRY_W-1:0]  wr_data;

  // Entries are only ever appended, so the valid ones are exactly 0 .. count_r-1.
  assign hit_now = rd_vld_r && (rd_node_r == key_node_r);
  assign issue   = cmd.search && !hit_now && (addr_r != count_r);
  assign full    = (count_r == CW'(TABLE_DEPTH));

  assign st.hit      = hit_now;
  assign st.done     = !rd_vld_r && (addr_r == count_r);
  assign st.out_free = !out_valid_r || out_ready;

  always_comb begin
    res_status_nxt = res_status_r;
    res_ip_nxt     = res_ip_r;
    count_nxt      = count_r;
    wr_en          = 1'b0;
    wr_idx         = rd_idx_r;
    wr_data        = {key_node_r, key_ip_r};
    if (cmd.resolve) begin
      if (hit_now) begin
        if (key_op_r == OP_LEARN) begin
          wr_en          = 1'b1;
          res_status_nxt = ST_UPDATED;
          res_ip_nxt     = key_ip_r;
        end else begin
          res_status_nxt = ST_HIT;
          res_ip_nxt     = rd_ip_r;
        end
      end else if (key_op_r == OP_LOOKUP) begin
        res_status_nxt = ST_MISS;
        res_ip_nxt     = '0;
      end else if (full) begin
        res_status_nxt = ST_FULL;
        res_ip_nxt     = '0;
      end else begin
        wr_en          = 1'b1;
        wr_idx         = count_r[AW-1:0];
        count_nxt      = CW'(count_r + 1'b1);
        res_status_nxt = ST_INSERTED;
        res_ip_nxt     = key_ip_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (issue) begin
      {rd_node_r, rd_ip_r} <= mem[addr_r[AW-1:0]];
      rd_idx_r             <= addr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_op_r   <= in_op;
      key_node_r <= in_node_address;
      key_ip_r   <= in_ip_address;
    end
    res_status_r <= res_status_nxt;
    res_ip_r     <= res_ip_nxt;
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_ip_r     <= res_ip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      addr_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.load) begin
        addr_r   <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        if (issue) begin
          addr_r <= CW'(addr_r + 1'b1);
        end
        rd_vld_r <= issue;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found_ip = out_ip_r;

endmodule

@@ sv/node_to_ip_learning_table.sv @@
// Top level of the node-to-IP learning table: controller, datapath and checks.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_op, in_node_address, in_ip_address
//   out_     output     out_valid / out_ready  out_status, out_found_ip
//
// An item scans the stored entries in order, from entry 0 up to a match or until all
// count entries are compared, where count is the number of stored entries (at most
// TABLE_DEPTH); the result then waits for a free output register. The table takes
// no new item until that result is pushed. The scan is bound by the single read
// port of the entry memory, which it walks one entry per cycle.
// Reset is synchronous and active low; it empties the table at once through the
// fill count, so no clearing pass is needed.
// A new item is accepted while a finished result still waits in the output
// register; only that next item's own result waits for the register to drain.
module node_to_ip_learning_table import ntip_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [NODE_W-1:0]   in_node_address,
  input  logic [IP_W-1:0]     in_ip_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [IP_W-1:0]     out_found_ip
);

  ntip_cmd_t  cmd;
  ntip_stat_t st;

  // The controller sequences each item through load, scan, resolve and push.
  ntip_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the entries, compares one per cycle and forms the result.
  ntip_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_node_address (in_node_address),
    .in_ip_address   (in_ip_address),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_ip    (out_found_ip)
  );

  // A match and an exhausted scan can never be reported together.
  a_hit_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    st.hit |-> !st.done)
    else $error("scan reported both a match and exhaustion");

  // Each item is resolved exactly once.
  a_single_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resolve |=> !cmd.resolve)
    else $error("item resolved twice in a row");

  // A pushed result shows up on the output in the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid)
    else $error("pushed result not presented");

  // Only defined status codes leave the block.
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_UPDATED || out_status == ST_INSERTED ||
                   out_status == ST_FULL || out_status == ST_HIT ||
                   out_status == ST_MISS))
    else $error("undefined result status");

endmodule
